>>> hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Fixed-delay implication.
`define ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/aar_pkg.sv
`default_nettype none
package aar_pkg;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     zero;
  } side_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 47;
  localparam logic [31:0] DIV_SEED  = 32'h0000_8000;
  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  localparam logic [31:0] ATAN_TURN [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage
`default_nettype wire

>>> hw/rtl/axis_angle_rotation_matrix.sv
// Throughput: one item per cycle; busy stays low and start may be high every cycle.
// Latency is set by the 32-step square root, the 47-step reciprocal divider and
// the CORDIC chain, each one register stage per step.
// Reset (rst, synchronous) clears every stage valid; no done follows until new starts.
`default_nettype none
`include "assert_macros.svh"
module axis_angle_rotation_matrix import aar_pkg::*; #(
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  request,
  output logic      done,
  output out_item_t result
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int SW  = 3 * UW + 1;
  localparam int LAT = 89 + CORDIC_STAGES;

  logic                 sq_valid;
  side_t                sq_side;
  logic [31:0]          sq_root;
  logic                 dv_valid;
  side_t                dv_side;
  logic [DIV_STEPS-1:0] dv_rs;
  logic                 nm_valid, nm_zero;
  logic [15:0]          nm_angle;
  logic signed [UW-1:0] nm_ux, nm_uy, nm_uz;
  logic                 cd_valid;
  logic [SW-1:0]        cd_side;
  logic signed [UW-1:0] cd_cos, cd_sin;

  assign busy = 1'b0;

  aar_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .in_item   (request),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .root      (sq_root)
  );

  aar_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .root      (sq_root),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .rs        (dv_rs)
  );

  aar_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_side   (dv_side),
    .rs        (dv_rs),
    .out_valid (nm_valid),
    .out_zero  (nm_zero),
    .out_angle (nm_angle),
    .ux        (nm_ux),
    .uy        (nm_uy),
    .uz        (nm_uz)
  );

  aar_cordic #(
    .FRAC_BITS     (FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .SW            (SW)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nm_valid),
    .in_side   ({nm_zero, nm_ux, nm_uy, nm_uz}),
    .angle     (nm_angle),
    .out_valid (cd_valid),
    .out_side  (cd_side),
    .cos_v     (cd_cos),
    .sin_v     (cd_sin)
  );

  aar_mat #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cd_valid),
    .in_zero   (cd_side[SW-1]),
    .ux        (cd_side[3*UW-1:2*UW]),
    .uy        (cd_side[2*UW-1:UW]),
    .uz        (cd_side[UW-1:0]),
    .cos_v     (cd_cos),
    .sin_v     (cd_sin),
    .out_valid (done),
    .out_item  (result)
  );

  `ASSERT_DELAY(a_start_gives_done, start && !busy, LAT, done)
  `ASSERT_IMPLIES(a_done_from_start, done, $past(start, LAT))
  `ASSERT_IMPLIES(a_degenerate_identity, done && result.degenerate,
                  result.m01 == 16'sd0 && result.m02 == 16'sd0 && result.m12 == 16'sd0)

endmodule
`default_nettype wire

>>> hw/rtl/aar_sqrt.sv
`default_nettype none
module aar_sqrt import aar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  in_item_t    in_item,
  output logic        out_valid,
  output side_t       out_side,
  output logic [31:0] root
);

  logic        valid_a;
  in_item_t    item_a;
  logic [31:0] sq_x, sq_y, sq_z;

  logic        valid_s [0:SQRT_STEPS];
  side_t       side_s  [0:SQRT_STEPS];
  logic [31:0] l2_s    [0:SQRT_STEPS];
  logic [34:0] rem_s   [0:SQRT_STEPS];
  logic [31:0] root_s  [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    valid_a <= rst ? 1'b0 : in_valid;
    item_a  <= in_item;
    sq_x    <= 32'(in_item.axis_x * in_item.axis_x);
    sq_y    <= 32'(in_item.axis_y * in_item.axis_y);
    sq_z    <= 32'(in_item.axis_z * in_item.axis_z);
  end

  always_ff @(posedge clk) begin
    valid_s[0]     <= rst ? 1'b0 : valid_a;
    side_s[0].item <= item_a;
    side_s[0].zero <= (sq_x + sq_y + sq_z) == 32'd0;
    l2_s[0]        <= sq_x + sq_y + sq_z;
    rem_s[0]       <= '0;
    root_s[0]      <= '0;
  end

  // One root bit per stage; the low half of the radicand is all zeros.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic [1:0]  pair;
    logic [34:0] rem_cat, trial;
    logic        ge;

    if (i < 16) begin : g_hi
      assign pair = l2_s[i][31-2*i -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    assign rem_cat = {rem_s[i][32:0], pair};
    assign trial   = {1'b0, root_s[i], 2'b01};
    assign ge      = rem_cat >= trial;

    always_ff @(posedge clk) begin
      valid_s[i+1] <= rst ? 1'b0 : valid_s[i];
      side_s[i+1]  <= side_s[i];
      l2_s[i+1]    <= l2_s[i];
      rem_s[i+1]   <= ge ? rem_cat - trial : rem_cat;
      root_s[i+1]  <= {root_s[i][30:0], ge};
    end
  end

  assign out_valid = valid_s[SQRT_STEPS];
  assign out_side  = side_s[SQRT_STEPS];
  assign root      = root_s[SQRT_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/aar_div.sv
`default_nettype none
module aar_div import aar_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic [31:0]          root,
  output logic                 out_valid,
  output side_t                out_side,
  output logic [DIV_STEPS-1:0] rs
);

  logic                 valid_s [0:DIV_STEPS];
  side_t                side_s  [0:DIV_STEPS];
  logic [31:0]          n_s     [0:DIV_STEPS];
  logic [31:0]          rem_s   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] q_s     [0:DIV_STEPS];

  // Dividend is 2^62 + n/2; its top bits above the quotient range seed the remainder.
  always_ff @(posedge clk) begin
    valid_s[0] <= rst ? 1'b0 : in_valid;
    side_s[0]  <= in_side;
    n_s[0]     <= root;
    rem_s[0]   <= DIV_SEED;
    q_s[0]     <= '0;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    localparam int K = DIV_STEPS - 1 - i;
    logic        dbit;
    logic [32:0] rem_cat;
    logic        ge;

    if (K <= 30) begin : g_bit
      assign dbit = n_s[i][K+1];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign rem_cat = {rem_s[i], dbit};
    assign ge      = rem_cat >= {1'b0, n_s[i]};

    always_ff @(posedge clk) begin
      valid_s[i+1] <= rst ? 1'b0 : valid_s[i];
      side_s[i+1]  <= side_s[i];
      n_s[i+1]     <= n_s[i];
      rem_s[i+1]   <= ge ? 32'(rem_cat - {1'b0, n_s[i]}) : rem_cat[31:0];
      q_s[i+1]     <= {q_s[i][DIV_STEPS-2:0], ge};
    end
  end

  assign out_valid = valid_s[DIV_STEPS];
  assign out_side  = side_s[DIV_STEPS];
  assign rs        = q_s[DIV_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/aar_norm.sv
`default_nettype none
module aar_norm import aar_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  side_t                       in_side,
  input  logic [DIV_STEPS-1:0]        rs,
  output logic                        out_valid,
  output logic                        out_zero,
  output logic [15:0]                 out_angle,
  output logic signed [FRAC_BITS+1:0] ux,
  output logic signed [FRAC_BITS+1:0] uy,
  output logic signed [FRAC_BITS+1:0] uz
);

  localparam int UW = FRAC_BITS + 2;
  localparam int SH = 46 - FRAC_BITS;
  localparam logic [63:0] HALF = 64'(1) << (SH - 1);

  logic        valid1;
  side_t       side1;
  logic [2:0]  neg1;
  logic [39:0] plo [0:2];
  logic [38:0] phi [0:2];
  logic [15:0] mag [0:2];
  logic signed [15:0] comp [0:2];
  logic signed [UW-1:0] unit [0:2];

  assign comp[0] = in_side.item.axis_x;
  assign comp[1] = in_side.item.axis_y;
  assign comp[2] = in_side.item.axis_z;

  // Split rs so each partial product stays narrow.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [63:0] full;
    logic [63:0] r;

    assign mag[k] = comp[k][15] ? 16'(-comp[k]) : 16'(comp[k]);
    assign full   = (64'(phi[k]) << 24) + 64'(plo[k]) + HALF;
    assign r      = full >> SH;

    always_ff @(posedge clk) begin
      neg1[k] <= comp[k][15];
      plo[k]  <= 40'(mag[k]) * 40'(rs[23:0]);
      phi[k]  <= 39'(mag[k]) * 39'(rs[DIV_STEPS-1:24]);
      unit[k] <= neg1[k] ? -UW'(r) : UW'(r);
    end
  end

  always_ff @(posedge clk) begin
    valid1    <= rst ? 1'b0 : in_valid;
    side1     <= in_side;
    out_valid <= rst ? 1'b0 : valid1;
    out_zero  <= side1.zero;
    out_angle <= side1.item.turn_angle;
  end

  assign ux = unit[0];
  assign uy = unit[1];
  assign uz = unit[2];

endmodule
`default_nettype wire

>>> hw/rtl/aar_cordic.sv
`default_nettype none
module aar_cordic import aar_pkg::*; #(
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16,
  parameter int SW            = 49
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [SW-1:0]               in_side,
  input  logic [15:0]                 angle,
  output logic                        out_valid,
  output logic [SW-1:0]               out_side,
  output logic signed [FRAC_BITS+1:0] cos_v,
  output logic signed [FRAC_BITS+1:0] sin_v
);

  localparam int XW  = 34;
  localparam int ZW  = 33;
  localparam int CW  = FRAC_BITS + 2;
  localparam int RSH = 30 - FRAC_BITS;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(32'h2000_0000);

  logic                 valid_s [0:CORDIC_STAGES];
  logic [SW-1:0]        side_s  [0:CORDIC_STAGES];
  logic [1:0]           q_s     [0:CORDIC_STAGES];
  logic signed [XW-1:0] x_s     [0:CORDIC_STAGES];
  logic signed [XW-1:0] y_s     [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_s     [0:CORDIC_STAGES];

  logic [31:0] shifted;
  logic signed [XW-1:0] csel, ssel, crnd, srnd;

  // Fold the angle to the nearest quadrant; the residual lies within one eighth turn.
  assign shifted = {angle, 16'h0000} + 32'h2000_0000;

  always_ff @(posedge clk) begin
    valid_s[0] <= rst ? 1'b0 : in_valid;
    side_s[0]  <= in_side;
    q_s[0]     <= shifted[31:30];
    x_s[0]     <= XW'(CORDIC_X0);
    y_s[0]     <= '0;
    z_s[0]     <= $signed({3'b000, shifted[29:0]}) - QUARTER;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TURN[i]);
    logic signed [XW-1:0] dx, dy;

    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;

    always_ff @(posedge clk) begin
      valid_s[i+1] <= rst ? 1'b0 : valid_s[i];
      side_s[i+1]  <= side_s[i];
      q_s[i+1]     <= q_s[i];
      if (!z_s[i][ZW-1]) begin
        x_s[i+1] <= x_s[i] - dx;
        y_s[i+1] <= y_s[i] + dy;
        z_s[i+1] <= z_s[i] - AT;
      end else begin
        x_s[i+1] <= x_s[i] + dx;
        y_s[i+1] <= y_s[i] - dy;
        z_s[i+1] <= z_s[i] + AT;
      end
    end
  end

  always_comb begin
    case (q_s[CORDIC_STAGES])
      2'd0: begin
        csel = x_s[CORDIC_STAGES];
        ssel = y_s[CORDIC_STAGES];
      end
      2'd1: begin
        csel = -y_s[CORDIC_STAGES];
        ssel = x_s[CORDIC_STAGES];
      end
      2'd2: begin
        csel = -x_s[CORDIC_STAGES];
        ssel = -y_s[CORDIC_STAGES];
      end
      default: begin
        csel = y_s[CORDIC_STAGES];
        ssel = -x_s[CORDIC_STAGES];
      end
    endcase
  end

  if (RSH > 0) begin : g_round
    localparam logic signed [XW-1:0] RND = XW'(1) <<< (RSH - 1);
    assign crnd = (csel + RND) >>> RSH;
    assign srnd = (ssel + RND) >>> RSH;
  end else begin : g_pass
    assign crnd = csel;
    assign srnd = ssel;
  end

  always_ff @(posedge clk) begin
    out_valid <= rst ? 1'b0 : valid_s[CORDIC_STAGES];
    out_side  <= side_s[CORDIC_STAGES];
    cos_v     <= CW'(crnd);
    sin_v     <= CW'(srnd);
  end

endmodule
`default_nettype wire

>>> hw/rtl/aar_mat.sv
`default_nettype none
module aar_mat import aar_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_zero,
  input  logic signed [FRAC_BITS+1:0] ux,
  input  logic signed [FRAC_BITS+1:0] uy,
  input  logic signed [FRAC_BITS+1:0] uz,
  input  logic signed [FRAC_BITS+1:0] cos_v,
  input  logic signed [FRAC_BITS+1:0] sin_v,
  output logic                        out_valid,
  output out_item_t                   out_item
);

  localparam int VW = FRAC_BITS + 4;
  localparam int PW = 2 * VW;
  localparam int EW = (VW + 1 > 17) ? VW + 1 : 17;
  localparam logic signed [VW-1:0] ONE = VW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] SAT_HI = EW'(32767);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
  localparam logic signed [15:0] DIAG = 16'((FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS));

  function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = p + RND;
    return VW'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [VW:0] v);
    logic signed [EW-1:0] ve;
    ve = EW'(v);
    if (ve > SAT_HI) begin
      return 16'sh7fff;
    end else if (ve < SAT_LO) begin
      return 16'sh8000;
    end
    return ve[15:0];
  endfunction

  logic signed [VW-1:0] x, y, z, c, s;
  assign x = VW'(ux);
  assign y = VW'(uy);
  assign z = VW'(uz);
  assign c = VW'(cos_v);
  assign s = VW'(sin_v);

  logic                 valid1, zero1;
  logic signed [VW-1:0] pxx, pyy, pzz, pxy, pxz, pyz, xs1, ys1, zs1, c1, t1;
  logic                 valid2, zero2;
  logic signed [VW-1:0] xxt, yyt, zzt, xyt, xzt, yzt, xs2, ys2, zs2, c2;

  always_ff @(posedge clk) begin
    valid1 <= rst ? 1'b0 : in_valid;
    zero1  <= in_zero;
    pxx    <= fmul(x, x);
    pyy    <= fmul(y, y);
    pzz    <= fmul(z, z);
    pxy    <= fmul(x, y);
    pxz    <= fmul(x, z);
    pyz    <= fmul(y, z);
    xs1    <= fmul(x, s);
    ys1    <= fmul(y, s);
    zs1    <= fmul(z, s);
    c1     <= c;
    t1     <= ONE - c;
  end

  always_ff @(posedge clk) begin
    valid2 <= rst ? 1'b0 : valid1;
    zero2  <= zero1;
    xxt    <= fmul(pxx, t1);
    yyt    <= fmul(pyy, t1);
    zzt    <= fmul(pzz, t1);
    xyt    <= fmul(pxy, t1);
    xzt    <= fmul(pxz, t1);
    yzt    <= fmul(pyz, t1);
    xs2    <= xs1;
    ys2    <= ys1;
    zs2    <= zs1;
    c2     <= c1;
  end

  // Zero-length axis: substitute the identity.
  always_ff @(posedge clk) begin
    out_valid <= rst ? 1'b0 : valid2;
    out_item.degenerate <= zero2;
    if (zero2) begin
      out_item.m00 <= DIAG;
      out_item.m01 <= '0;
      out_item.m02 <= '0;
      out_item.m10 <= '0;
      out_item.m11 <= DIAG;
      out_item.m12 <= '0;
      out_item.m20 <= '0;
      out_item.m21 <= '0;
      out_item.m22 <= DIAG;
    end else begin
      out_item.m00 <= sat16((VW+1)'(xxt) + (VW+1)'(c2));
      out_item.m01 <= sat16((VW+1)'(xyt) + (VW+1)'(zs2));
      out_item.m02 <= sat16((VW+1)'(xzt) - (VW+1)'(ys2));
      out_item.m10 <= sat16((VW+1)'(xyt) - (VW+1)'(zs2));
      out_item.m11 <= sat16((VW+1)'(yyt) + (VW+1)'(c2));
      out_item.m12 <= sat16((VW+1)'(yzt) + (VW+1)'(xs2));
      out_item.m20 <= sat16((VW+1)'(xzt) + (VW+1)'(ys2));
      out_item.m21 <= sat16((VW+1)'(yzt) - (VW+1)'(xs2));
      out_item.m22 <= sat16((VW+1)'(zzt) + (VW+1)'(c2));
    end
  end

endmodule
`default_nettype wire
